@@ src/arpc_pkg.sv @@
package arpc_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_UPSERT = 2'd1;
	localparam logic [1:0] ACT_PRUNE  = 2'd2;

	localparam logic CFG_TTL = 1'b0;
	localparam logic CFG_MAX = 1'b1;

	localparam logic [31:0]      TTL_RST = 32'd60000;
	localparam logic [CNT_W-1:0] MAX_RST = CNT_W'(ENTRIES);

	// rank adjust applied by the update sweep
	typedef enum logic [1:0] {
		MODE_INC_LT  = 2'd0,
		MODE_INC_ALL = 2'd1,
		MODE_DEC_GT  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [31:0]      ip;
		logic [47:0]      mac;
		logic [31:0]      seen;
		logic [IDX_W-1:0] rank;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic             load;
		logic             find_clr;
		logic             rd_en;
		logic             rd_upd;
		logic [IDX_W-1:0] rd_addr;
		logic             decide;
		logic             wr_tgt;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic plan_refind;
		logic plan_upd;
		logic plan_wr;
	} sts_t;

endpackage

@@ src/arpc_ram.sv @@
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/arpc_ctrl.sv @@
module arpc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  arpc_pkg::sts_t  sts,
	output arpc_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_FIND   = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_UPD    = 6'b001000,
		ST_WRITE  = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [arpc_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;
	logic wr_pend_q, wr_pend_d;
	logic sweep_end;

	assign sweep_end = (cnt_q == arpc_pkg::CNT_W'(arpc_pkg::ENTRIES));
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		out_valid_d  = out_valid_q;
		wr_pend_d    = wr_pend_q;
		cmd          = '0;
		cmd.rd_addr  = cnt_q[arpc_pkg::IDX_W-1:0];
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_FIND;
				end
			end
			ST_FIND: begin
				cmd.find_clr = (cnt_q == '0);
				cmd.rd_en    = !sweep_end;
				if (sweep_end) begin
					cnt_d   = '0;
					state_d = ST_DECIDE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				// hold the write plan; the decide inputs move once it commits
				wr_pend_d  = sts.plan_wr;
				if (sts.plan_refind) begin
					state_d = ST_FIND;
				end else if (sts.plan_upd) begin
					state_d = ST_UPD;
				end else if (sts.plan_wr) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_UPD: begin
				cmd.rd_en  = !sweep_end;
				cmd.rd_upd = 1'b1;
				if (sweep_end) begin
					cnt_d   = '0;
					state_d = wr_pend_q ? ST_WRITE : ST_RESULT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_WRITE: begin
				cmd.wr_tgt = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				// hold while the previous word is still unclaimed
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			wr_pend_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
			wr_pend_q   <= wr_pend_d;
		end
	end

endmodule

@@ src/arpc_dp.sv @@
module arpc_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  arpc_pkg::cmd_t             cmd,
	output arpc_pkg::sts_t             sts,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [31:0]                cfg_data,
	input  logic [1:0]                 action,
	input  logic [31:0]                ip_addr,
	input  logic [47:0]                mac_in,
	input  logic [31:0]                now_ms,
	output logic                       hit,
	output logic [47:0]                mac_out,
	output logic [arpc_pkg::CNT_W-1:0] removed_count,
	output logic [arpc_pkg::CNT_W-1:0] entry_count
);

	localparam int IW = arpc_pkg::IDX_W;
	localparam int CW = arpc_pkg::CNT_W;

	logic [31:0]   ttl_q;
	logic [CW-1:0] max_q;

	logic [1:0]  action_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [31:0] now_q;

	logic [arpc_pkg::ENTRIES-1:0] valid_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] removed_q;
	logic          hit_q;
	logic [47:0]   hmac_q;

	logic                 m_found_q, v_found_q, f_found_q;
	logic [IW-1:0]        m_idx_q, v_idx_q, f_idx_q;
	arpc_pkg::row_t       m_row_q, v_row_q;

	logic                 rd_s1, upd_s1;
	logic [IW-1:0]        addr_s1;
	logic [arpc_pkg::ROW_W-1:0] rdata;
	arpc_pkg::row_t       row_s1;

	arpc_pkg::mode_t      mode_q;
	logic [IW-1:0]        r_q;
	logic [IW-1:0]        tgt_q;
	arpc_pkg::row_t       tgt_row_q;

	// decision, evaluated from the finished search
	logic                 d_refind, d_upd, d_wr;
	logic                 d_clr, d_set, d_inc, d_dec, d_hit, d_rem;
	logic [IW-1:0]        d_idx;
	arpc_pkg::mode_t      d_mode;
	logic [IW-1:0]        d_r;
	arpc_pkg::row_t       d_row;
	logic                 exp_m, exp_v;
	logic [CW-1:0]        lim;
	logic [CW-1:0]        tm1;

	logic                 we;
	logic [IW-1:0]        waddr;
	arpc_pkg::row_t       wrow;
	arpc_pkg::row_t       urow;
	logic                 uwr;

	assign row_s1 = arpc_pkg::row_t'(rdata);
	assign tm1    = total_q - CW'(1);
	assign exp_m  = (now_q - m_row_q.seen) > ttl_q;
	assign exp_v  = (now_q - v_row_q.seen) > ttl_q;
	assign lim    = (max_q > CW'(arpc_pkg::ENTRIES)) ? CW'(arpc_pkg::ENTRIES) : max_q;

	always_comb begin
		d_refind = 1'b0;
		d_upd    = 1'b0;
		d_wr     = 1'b0;
		d_clr    = 1'b0;
		d_set    = 1'b0;
		d_inc    = 1'b0;
		d_dec    = 1'b0;
		d_hit    = 1'b0;
		d_rem    = 1'b0;
		d_idx    = m_idx_q;
		d_mode   = arpc_pkg::MODE_INC_LT;
		d_r      = m_row_q.rank;
		d_row.ip   = ip_q;
		d_row.mac  = mac_q;
		d_row.seen = now_q;
		d_row.rank = '0;
		case (action_q)
			arpc_pkg::ACT_LOOKUP: begin
				if (m_found_q) begin
					d_upd = 1'b1;
					if (exp_m) begin
						d_clr  = 1'b1;
						d_dec  = 1'b1;
						d_rem  = 1'b1;
						d_mode = arpc_pkg::MODE_DEC_GT;
					end else begin
						d_hit     = 1'b1;
						d_wr      = 1'b1;
						d_row.ip  = m_row_q.ip;
						d_row.mac = m_row_q.mac;
					end
				end
			end
			arpc_pkg::ACT_UPSERT: begin
				if (m_found_q) begin
					d_upd = 1'b1;
					d_wr  = 1'b1;
				end else if (total_q >= lim) begin
					// reuse the least recent slot in place
					if (total_q != '0 && v_found_q) begin
						d_upd  = 1'b1;
						d_wr   = 1'b1;
						d_rem  = 1'b1;
						d_idx  = v_idx_q;
						d_mode = arpc_pkg::MODE_INC_ALL;
					end
				end else if (f_found_q) begin
					d_upd  = 1'b1;
					d_wr   = 1'b1;
					d_set  = 1'b1;
					d_inc  = 1'b1;
					d_idx  = f_idx_q;
					d_mode = arpc_pkg::MODE_INC_ALL;
				end
			end
			arpc_pkg::ACT_PRUNE: begin
				// the least recent entry carries the top rank: drop it, no reorder
				if (total_q != '0 && v_found_q && exp_v) begin
					d_refind = 1'b1;
					d_clr    = 1'b1;
					d_dec    = 1'b1;
					d_rem    = 1'b1;
					d_idx    = v_idx_q;
				end
			end
			default: ;
		endcase
	end

	assign sts.plan_refind = d_refind;
	assign sts.plan_upd    = d_upd;
	assign sts.plan_wr     = d_wr;

	always_comb begin
		urow = row_s1;
		uwr  = rd_s1 && upd_s1 && valid_q[addr_s1] && (addr_s1 != tgt_q);
		case (mode_q)
			arpc_pkg::MODE_INC_LT:  if (row_s1.rank < r_q) urow.rank = row_s1.rank + 1'b1;
			arpc_pkg::MODE_INC_ALL: urow.rank = row_s1.rank + 1'b1;
			arpc_pkg::MODE_DEC_GT:  if (row_s1.rank > r_q) urow.rank = row_s1.rank - 1'b1;
			default: ;
		endcase
	end

	assign we    = uwr || cmd.wr_tgt;
	assign waddr = cmd.wr_tgt ? tgt_q : addr_s1;
	assign wrow  = cmd.wr_tgt ? tgt_row_q : urow;

	arpc_ram #(
		.WIDTH(arpc_pkg::ROW_W),
		.DEPTH(arpc_pkg::ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wrow),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q   <= arpc_pkg::TTL_RST;
			max_q   <= arpc_pkg::MAX_RST;
			valid_q <= '0;
			total_q <= '0;
			rd_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					arpc_pkg::CFG_TTL: ttl_q <= cfg_data;
					arpc_pkg::CFG_MAX: max_q <= cfg_data[CW-1:0];
					default: ;
				endcase
			end
			rd_s1 <= cmd.rd_en;
			if (cmd.decide) begin
				if (d_clr) valid_q[d_idx] <= 1'b0;
				if (d_set) valid_q[d_idx] <= 1'b1;
				if (d_inc) total_q <= total_q + 1'b1;
				if (d_dec) total_q <= total_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cmd.rd_addr;
		upd_s1  <= cmd.rd_upd;
		if (cmd.load) begin
			action_q  <= action;
			ip_q      <= ip_addr;
			mac_q     <= mac_in;
			now_q     <= now_ms;
			removed_q <= '0;
			hit_q     <= 1'b0;
			hmac_q    <= '0;
		end
		if (cmd.find_clr) begin
			m_found_q <= 1'b0;
			v_found_q <= 1'b0;
			f_found_q <= 1'b0;
		end else if (rd_s1 && !upd_s1) begin
			if (valid_q[addr_s1] && row_s1.ip == ip_q && !m_found_q) begin
				m_found_q <= 1'b1;
				m_idx_q   <= addr_s1;
				m_row_q   <= row_s1;
			end
			if (valid_q[addr_s1] && row_s1.rank == tm1[IW-1:0] && !v_found_q) begin
				v_found_q <= 1'b1;
				v_idx_q   <= addr_s1;
				v_row_q   <= row_s1;
			end
			if (!valid_q[addr_s1] && !f_found_q) begin
				f_found_q <= 1'b1;
				f_idx_q   <= addr_s1;
			end
		end
		if (cmd.decide) begin
			mode_q    <= d_mode;
			r_q       <= d_r;
			tgt_q     <= d_idx;
			tgt_row_q <= d_row;
			if (d_rem) removed_q <= removed_q + 1'b1;
			if (d_hit) begin
				hit_q  <= 1'b1;
				hmac_q <= m_row_q.mac;
			end
		end
		if (cmd.out_load) begin
			hit           <= hit_q;
			mac_out       <= hmac_q;
			removed_count <= removed_q;
			entry_count   <= total_q;
		end
	end

endmodule

@@ src/arp_cache_lru_ttl_unit.sv @@
// Operation: a search sweep over the table, a decide step, an optional
// rank update sweep over the table and an optional row write, then the result.
// A prune repeats search and decide once per expired entry it removes.
// Throughput: one word per operation; the table sweeps bound it, and a new word is taken only when idle.
// Reset: arst_n clears valid bits, entry count and control; ttl_ms is 60000
// and soft_max_entries is 64. Table rows are not cleared.
module arp_cache_lru_ttl_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration writes: index 0 ttl_ms, index 1 soft_max_entries
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [31:0]                cfg_data,
	// operation words
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic [31:0]                ip_addr,
	input  logic [47:0]                mac_in,
	input  logic [31:0]                now_ms,
	// result words, held in an output register until taken
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       hit,
	output logic [47:0]                mac_out,
	output logic [arpc_pkg::CNT_W-1:0] removed_count,
	output logic [arpc_pkg::CNT_W-1:0] entry_count
);

	arpc_pkg::cmd_t cmd;
	arpc_pkg::sts_t sts;

	// sequencer: search sweep, decide, rank sweep, row write, result
	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table, valid bits, match capture and result registers
	arpc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.ip_addr       (ip_addr),
		.mac_in        (mac_in),
		.now_ms        (now_ms),
		.hit           (hit),
		.mac_out       (mac_out),
		.removed_count (removed_count),
		.entry_count   (entry_count)
	);

endmodule

@@ src/arpc_checker.sv @@
module arpc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       hit,
	input logic [47:0]                mac_out,
	input logic [arpc_pkg::CNT_W-1:0] removed_count,
	input logic [arpc_pkg::CNT_W-1:0] entry_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a word while busy");

	a_miss_mac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> mac_out == '0)
		else $error("nonzero mac on miss");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= arpc_pkg::CNT_W'(arpc_pkg::ENTRIES)
			&& removed_count <= arpc_pkg::CNT_W'(arpc_pkg::ENTRIES))
		else $error("count out of range");

endmodule

bind arp_cache_lru_ttl_unit arpc_checker u_chk (.*);
